[rtl/h4rx_pkg.sv]
// ----------------------------------------------------------------------------
// h4rx_pkg
// Shared types and codes of the HCI H4 UART receive deframer.
// ----------------------------------------------------------------------------
package h4rx_pkg;

    localparam int unsigned INDEX_W = 17;

    localparam logic [2:0] TYPE_NONE = 3'd0;
    localparam logic [2:0] TYPE_CMD  = 3'd1;
    localparam logic [2:0] TYPE_ACL  = 3'd2;
    localparam logic [2:0] TYPE_EVT  = 3'd4;

    localparam logic [INDEX_W-1:0] HDR_CMD     = 17'd3;
    localparam logic [INDEX_W-1:0] HDR_EVT     = 17'd2;
    localparam logic [INDEX_W-1:0] HDR_ACL     = 17'd4;
    localparam logic [INDEX_W-1:0] ACL_LEN_LOW = 17'd3;

    localparam logic [1:0] KIND_TYPE    = 2'd0;
    localparam logic [1:0] KIND_CONTENT = 2'd1;
    localparam logic [1:0] KIND_DROP    = 2'd2;

    typedef struct packed {
        logic [7:0]         out_byte;
        logic [1:0]         kind;
        logic [2:0]         packet_type;
        logic [INDEX_W-1:0] byte_index;
        logic               last;
    } t_result;

endpackage

[rtl/hci_h4_uart_rx_deframer.sv]
// ----------------------------------------------------------------------------
// hci_h4_uart_rx_deframer
// Splits a received HCI H4 UART byte stream into packets, one result per byte.
// ----------------------------------------------------------------------------
// usage:
//   rx channel (i_rx_valid / o_rx_ready / i_rx_byte) takes one uart byte per
//   word. res channel (o_res_valid / i_res_ready) gives one word per byte:
//   the byte, its kind (type, content, dropped), the packet type, the index
//   of a content byte and a last flag on the final byte of a packet.
//   path: an accepted byte goes to the input register, then to the result
//   register behind the decode logic; a result stall can hold it in between.
//   throughput: one byte per cycle while results are taken; packet state is
//   updated as a byte moves from the input register to the result register.
//   reset: synchronous, active low; both registers empty, parser idle.
//   stall: while i_res_ready is low the result holds and one more byte can
//   still be taken into the input register; then o_rx_ready drops.
// ----------------------------------------------------------------------------
module hci_h4_uart_rx_deframer (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_rx_valid,
    output logic        o_rx_ready,
    input  logic [7:0]  i_rx_byte,
    output logic        o_res_valid,
    input  logic        i_res_ready,
    output logic [7:0]  o_out_byte,
    output logic [1:0]  o_kind,
    output logic [2:0]  o_packet_type,
    output logic [16:0] o_byte_index,
    output logic        o_last
);

    logic              r_in_valid;
    logic [7:0]        r_in_byte;
    logic              r_out_valid;
    h4rx_pkg::t_result r_out;
    h4rx_pkg::t_result step_res;
    logic              advance;

    assign advance    = r_in_valid && (!r_out_valid || i_res_ready);
    assign o_rx_ready = !r_in_valid || advance;

    h4rx_parser u_parser (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (advance),
        .i_byte  (r_in_byte),
        .o_res   (step_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_rx_ready) begin
                r_in_valid <= i_rx_valid;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
            end else if (i_res_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_rx_ready && i_rx_valid) begin
            r_in_byte <= i_rx_byte;
        end
        if (advance) begin
            r_out <= step_res;
        end
    end

    assign o_res_valid   = r_out_valid;
    assign o_out_byte    = r_out.out_byte;
    assign o_kind        = r_out.kind;
    assign o_packet_type = r_out.packet_type;
    assign o_byte_index  = r_out.byte_index;
    assign o_last        = r_out.last;

    a_type_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && o_kind == h4rx_pkg::KIND_TYPE) |->
            (o_byte_index == '0 && !o_last && o_packet_type != h4rx_pkg::TYPE_NONE))
        else $error("type word with index, last or no type");

    a_drop_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && o_kind == h4rx_pkg::KIND_DROP) |->
            (o_packet_type == h4rx_pkg::TYPE_NONE && !o_last))
        else $error("dropped word carries a packet type");

    a_last_content: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && o_last) |-> (o_kind == h4rx_pkg::KIND_CONTENT))
        else $error("last flag on a non-content word");

    a_pipe_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !advance) |=> (r_in_valid && $stable(r_in_byte)))
        else $error("pending input byte lost");

endmodule

[rtl/h4rx_parser.sv]
// ----------------------------------------------------------------------------
// h4rx_parser
// Packet state and per-byte decode: type selection, content count and
// length capture from the command, event or ACL header.
// ----------------------------------------------------------------------------
module h4rx_parser (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_step,
    input  logic [7:0]        i_byte,
    output h4rx_pkg::t_result o_res
);

    localparam int unsigned W = h4rx_pkg::INDEX_W;

    logic [2:0]   r_type, n_type;
    logic [W-1:0] r_seen, n_seen;
    logic [W-1:0] r_target, n_target;
    logic [7:0]   r_low, n_low;

    logic [W-1:0] count;
    logic [W-1:0] hdr;
    logic         busy;
    logic         last;

    assign busy  = (r_type == h4rx_pkg::TYPE_CMD) || (r_type == h4rx_pkg::TYPE_ACL) ||
                   (r_type == h4rx_pkg::TYPE_EVT);
    assign count = r_seen + W'(1);

    always_comb begin
        n_type   = r_type;
        n_seen   = r_seen;
        n_target = r_target;
        n_low    = r_low;
        hdr      = h4rx_pkg::HDR_ACL;
        last     = 1'b0;

        o_res.out_byte    = i_byte;
        o_res.kind        = h4rx_pkg::KIND_DROP;
        o_res.packet_type = h4rx_pkg::TYPE_NONE;
        o_res.byte_index  = '0;
        o_res.last        = 1'b0;

        if (!busy) begin
            if ((i_byte == 8'(h4rx_pkg::TYPE_CMD)) || (i_byte == 8'(h4rx_pkg::TYPE_ACL)) ||
                (i_byte == 8'(h4rx_pkg::TYPE_EVT))) begin
                n_type            = i_byte[2:0];
                n_seen            = '0;
                n_target          = '0;
                n_low             = '0;
                o_res.kind        = h4rx_pkg::KIND_TYPE;
                o_res.packet_type = i_byte[2:0];
            end else begin
                n_type = h4rx_pkg::TYPE_NONE;
            end
        end else begin
            n_seen = count;
            case (r_type)
                h4rx_pkg::TYPE_CMD: begin
                    hdr = h4rx_pkg::HDR_CMD;
                    if (count == h4rx_pkg::HDR_CMD) begin
                        n_target = W'(i_byte) + h4rx_pkg::HDR_CMD;
                    end
                end
                h4rx_pkg::TYPE_EVT: begin
                    hdr = h4rx_pkg::HDR_EVT;
                    if (count == h4rx_pkg::HDR_EVT) begin
                        n_target = W'(i_byte) + h4rx_pkg::HDR_EVT;
                    end
                end
                default: begin
                    hdr = h4rx_pkg::HDR_ACL;
                    if (count == h4rx_pkg::ACL_LEN_LOW) begin
                        n_low = i_byte;
                    end
                    if (count == h4rx_pkg::HDR_ACL) begin
                        n_target = W'({i_byte, r_low}) + h4rx_pkg::HDR_ACL;
                    end
                end
            endcase

            last = (count >= hdr) && (count == n_target);

            o_res.kind        = h4rx_pkg::KIND_CONTENT;
            o_res.packet_type = r_type;
            o_res.byte_index  = r_seen;
            o_res.last        = last;

            if (last) begin
                n_type = h4rx_pkg::TYPE_NONE;
                n_seen = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_type   <= h4rx_pkg::TYPE_NONE;
            r_seen   <= '0;
            r_target <= '0;
            r_low    <= '0;
        end else if (i_step) begin
            r_type   <= n_type;
            r_seen   <= n_seen;
            r_target <= n_target;
            r_low    <= n_low;
        end
    end

endmodule

[bench/hci_h4_uart_rx_deframer_test.sv]
// ----------------------------------------------------------------------------
// hci_h4_uart_rx_deframer_test
// Drives HCI H4 byte streams (dropped type bytes, command, ACL and event
// packets of zero, short and long length, command and event packets of
// largest length, plus random noise) through the deframer with random gaps
// and stalls on both sides and one long receiver hold-off. Every result word
// is checked against a cycle-free model of the packet parser.
// ----------------------------------------------------------------------------
module hci_h4_uart_rx_deframer_test;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned CYCLE_LIMIT = 1000000;
    localparam int unsigned HOLD_CYCLES = 80;
    localparam int unsigned W = h4rx_pkg::INDEX_W;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_rx_valid = 1'b0;
    logic        o_rx_ready;
    logic [7:0]  i_rx_byte = 8'd0;
    logic        o_res_valid;
    logic        i_res_ready = 1'b0;
    logic [7:0]  o_out_byte;
    logic [1:0]  o_kind;
    logic [2:0]  o_packet_type;
    logic [16:0] o_byte_index;
    logic        o_last;

    hci_h4_uart_rx_deframer dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_rx_valid    (i_rx_valid),
        .o_rx_ready    (o_rx_ready),
        .i_rx_byte     (i_rx_byte),
        .o_res_valid   (o_res_valid),
        .i_res_ready   (i_res_ready),
        .o_out_byte    (o_out_byte),
        .o_kind        (o_kind),
        .o_packet_type (o_packet_type),
        .o_byte_index  (o_byte_index),
        .o_last        (o_last)
    );

    logic [7:0]         uart_bytes [$];
    h4rx_pkg::t_result  parse_queue [$];
    int unsigned        queued_total = 0;
    int unsigned        accepted_total = 0;
    int unsigned        mismatch_count = 0;
    int unsigned        cycle_count = 0;
    int unsigned        rx_gap_pct = 0;
    int unsigned        res_stall_pct = 0;
    int unsigned        rx_gap_left = 0;
    int unsigned        res_stall_left = 0;
    int unsigned        hold_req = 0;
    int unsigned        hold_seen = 0;
    int unsigned        hold_left = 0;
    logic               rx_fire = 1'b0;

    logic [2:0]         frame_type = h4rx_pkg::TYPE_NONE;
    logic [W-1:0]       frame_seen = '0;
    logic [W-1:0]       frame_target = '0;
    logic [7:0]         frame_len_low = 8'd0;

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    function automatic h4rx_pkg::t_result deframe_byte(input logic [7:0] b);
        h4rx_pkg::t_result r;
        logic [W-1:0]      idx;
        logic [W-1:0]      cnt;
        logic [W-1:0]      hdr;
        r = '0;
        r.out_byte = b;
        if (frame_type != h4rx_pkg::TYPE_CMD && frame_type != h4rx_pkg::TYPE_ACL &&
            frame_type != h4rx_pkg::TYPE_EVT) begin
            if (b == {5'd0, h4rx_pkg::TYPE_CMD} || b == {5'd0, h4rx_pkg::TYPE_ACL} ||
                b == {5'd0, h4rx_pkg::TYPE_EVT}) begin
                frame_type = b[2:0];
                frame_seen = '0;
                frame_target = '0;
                frame_len_low = 8'd0;
                r.kind = h4rx_pkg::KIND_TYPE;
                r.packet_type = b[2:0];
            end else begin
                frame_type = h4rx_pkg::TYPE_NONE;
                r.kind = h4rx_pkg::KIND_DROP;
                r.packet_type = h4rx_pkg::TYPE_NONE;
            end
            return r;
        end
        idx = frame_seen;
        cnt = idx + 1'b1;
        frame_seen = cnt;
        if (frame_type == h4rx_pkg::TYPE_CMD) begin
            hdr = h4rx_pkg::HDR_CMD;
            if (cnt == h4rx_pkg::HDR_CMD)
                frame_target = {9'd0, b} + h4rx_pkg::HDR_CMD;
        end else if (frame_type == h4rx_pkg::TYPE_EVT) begin
            hdr = h4rx_pkg::HDR_EVT;
            if (cnt == h4rx_pkg::HDR_EVT)
                frame_target = {9'd0, b} + h4rx_pkg::HDR_EVT;
        end else begin
            hdr = h4rx_pkg::HDR_ACL;
            if (cnt == h4rx_pkg::ACL_LEN_LOW)
                frame_len_low = b;
            if (cnt == h4rx_pkg::HDR_ACL)
                frame_target = {1'b0, b, frame_len_low} + h4rx_pkg::HDR_ACL;
        end
        r.kind = h4rx_pkg::KIND_CONTENT;
        r.packet_type = frame_type;
        r.byte_index = idx;
        r.last = (cnt >= hdr) && (cnt == frame_target);
        if (r.last) begin
            frame_type = h4rx_pkg::TYPE_NONE;
            frame_seen = '0;
        end
        return r;
    endfunction

    function automatic int unsigned pick_gap(input int unsigned pct);
        if ($urandom_range(99) >= pct)
            return 0;
        if ($urandom_range(9) == 0)
            return $urandom_range(30, 8);
        return $urandom_range(3, 1);
    endfunction

    task automatic put_byte(input logic [7:0] b);
        uart_bytes.push_back(b);
        queued_total++;
    endtask

    task automatic add_packet(input logic [2:0] ptype, input int unsigned plen);
        logic [15:0] len16;
        len16 = plen[15:0];
        put_byte({5'd0, ptype});
        case (ptype)
            h4rx_pkg::TYPE_CMD: begin
                put_byte(8'($urandom_range(255)));
                put_byte(8'($urandom_range(255)));
                put_byte(len16[7:0]);
            end
            h4rx_pkg::TYPE_EVT: begin
                put_byte(8'($urandom_range(255)));
                put_byte(len16[7:0]);
            end
            default: begin
                put_byte(8'($urandom_range(255)));
                put_byte(8'($urandom_range(255)));
                put_byte(len16[7:0]);
                put_byte(len16[15:8]);
            end
        endcase
        repeat (plen) put_byte(8'($urandom_range(255)));
    endtask

    task automatic random_traffic(input int unsigned n);
        int unsigned stop_at;
        int unsigned pick;
        int unsigned plen;
        logic [2:0]  ptype;
        stop_at = queued_total + n;
        while (queued_total < stop_at) begin
            pick = $urandom_range(99);
            if (pick < 10) begin
                put_byte(8'($urandom_range(255)));
            end else begin
                if (pick < 40)
                    ptype = h4rx_pkg::TYPE_CMD;
                else if (pick < 70)
                    ptype = h4rx_pkg::TYPE_EVT;
                else
                    ptype = h4rx_pkg::TYPE_ACL;
                plen = ($urandom_range(99) < 85) ? $urandom_range(12) : $urandom_range(60);
                if (ptype == h4rx_pkg::TYPE_ACL && $urandom_range(49) == 0)
                    plen = $urandom_range(300, 256);
                add_packet(ptype, plen);
            end
        end
    endtask

    task automatic wait_drained();
        while (accepted_total != queued_total || parse_queue.size() != 0)
            @(posedge i_clk);
    endtask

    // sender
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_rx_valid <= 1'b0;
        end else if (!i_rx_valid || rx_fire) begin
            if (rx_gap_left > 0) begin
                rx_gap_left--;
                i_rx_valid <= 1'b0;
            end else if (uart_bytes.size() > 0) begin
                i_rx_byte <= uart_bytes.pop_front();
                i_rx_valid <= 1'b1;
                rx_gap_left = pick_gap(rx_gap_pct);
            end else begin
                i_rx_valid <= 1'b0;
            end
        end
    end

    // receiver, with the long hold-off counted here
    always @(negedge i_clk) begin
        if (hold_seen != hold_req) begin
            hold_seen = hold_req;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_res_ready <= 1'b0;
        end else if (res_stall_left > 0) begin
            res_stall_left--;
            i_res_ready <= 1'b0;
        end else begin
            res_stall_left = pick_gap(res_stall_pct);
            i_res_ready <= 1'b1;
        end
    end

    // monitor and scoreboard
    always @(posedge i_clk) begin : monitor
        h4rx_pkg::t_result got;
        h4rx_pkg::t_result want;
        rx_fire = i_rst_n && i_rx_valid && o_rx_ready;
        if (i_rst_n && o_res_valid && i_res_ready) begin
            got.out_byte = o_out_byte;
            got.kind = o_kind;
            got.packet_type = o_packet_type;
            got.byte_index = o_byte_index;
            got.last = o_last;
            if (parse_queue.size() == 0) begin
                if (mismatch_count < 10)
                    $display("unexpected word: byte %h kind %0d type %0d index %0d last %0d",
                             got.out_byte, got.kind, got.packet_type, got.byte_index, got.last);
                mismatch_count++;
            end else begin
                want = parse_queue.pop_front();
                if (got.out_byte !== want.out_byte || got.kind !== want.kind ||
                    got.packet_type !== want.packet_type ||
                    got.byte_index !== want.byte_index || got.last !== want.last) begin
                    if (mismatch_count < 10)
                        $display({"mismatch: want byte %h kind %0d type %0d index %0d last %0d,",
                                  " got byte %h kind %0d type %0d index %0d last %0d"},
                                 want.out_byte, want.kind, want.packet_type,
                                 want.byte_index, want.last,
                                 got.out_byte, got.kind, got.packet_type,
                                 got.byte_index, got.last);
                    mismatch_count++;
                end
            end
        end
        if (rx_fire) begin
            parse_queue.push_back(deframe_byte(i_rx_byte));
            accepted_total++;
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("hci_h4_uart_rx_deframer test failed");
            $finish;
        end
    end

    initial begin
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed, no idling
        rx_gap_pct = 0;
        res_stall_pct = 0;
        put_byte(8'h00);
        put_byte(8'h03);
        put_byte(8'hFF);
        put_byte(8'h05);
        add_packet(h4rx_pkg::TYPE_CMD, 0);
        add_packet(h4rx_pkg::TYPE_EVT, 0);
        add_packet(h4rx_pkg::TYPE_ACL, 0);
        add_packet(h4rx_pkg::TYPE_CMD, 1);
        put_byte({5'd0, h4rx_pkg::TYPE_EVT});
        put_byte(8'h0F);
        put_byte(8'h02);
        put_byte({5'd0, h4rx_pkg::TYPE_CMD});
        put_byte({5'd0, h4rx_pkg::TYPE_EVT});
        wait_drained();

        rx_gap_pct = 25;
        res_stall_pct = 25;
        random_traffic(80);

        // receiver holds off while the sender keeps offering
        rx_gap_pct = 0;
        hold_req++;
        random_traffic(30);

        rx_gap_pct = 50;
        res_stall_pct = 10;
        random_traffic(40);
        rx_gap_pct = 10;
        res_stall_pct = 50;
        random_traffic(40);

        // largest command and event lengths, no idling
        wait_drained();
        rx_gap_pct = 0;
        res_stall_pct = 0;
        add_packet(h4rx_pkg::TYPE_CMD, 255);
        add_packet(h4rx_pkg::TYPE_EVT, 255);
        put_byte(8'h00);

        wait_drained();
        repeat (8) @(posedge i_clk);
        if (mismatch_count == 0 && parse_queue.size() == 0)
            $display("hci_h4_uart_rx_deframer test passed");
        else
            $display("hci_h4_uart_rx_deframer test failed");
        $finish;
    end

endmodule
